/* rtl/mvn_pkg.sv */
package mvn_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_BITS_DEF   = 16;

   // Fixed field and datapath widths
   localparam int COORD_PORT_BITS = 16;
   localparam int COORD_BITS_MAX  = 24;
   localparam int IDX_BITS        = 10;
   localparam int CORNER_BITS     = 16;
   localparam int VCOUNT_BITS     = 11;
   localparam int LIM_BITS        = 17;
   localparam int SUM_BITS        = 51;
   localparam int OUT_BITS        = 35;
   localparam int COUNT_BITS      = 16;
   localparam int MUL_BITS        = 31;
   localparam int PROD_BITS       = 2 * MUL_BITS;
   localparam int DIV_N_BITS      = 51;
   localparam int DIV_D_BITS      = 31;
   localparam int DIV_CNT_BITS    = $clog2(DIV_N_BITS);
   localparam int SQ_BITS         = 62;
   localparam int ROOT_BITS       = 31;
   localparam int Q14_SHIFT       = 14;
   localparam int CSR_IDX_BITS    = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [DIV_N_BITS-1:0] ONE_Q14   = DIV_N_BITS'(1) << Q14_SHIFT;

   // Operation codes
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FACE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REPEAT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   // Result kinds
   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_NORMALIZE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_COUNT = 2'd1;

   // One row of the accumulation store
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum_x;
      logic signed [SUM_BITS-1:0] sum_y;
      logic signed [SUM_BITS-1:0] sum_z;
      logic [COUNT_BITS-1:0]      count;
   } row_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_N_BITS-1:0] dividend;
      logic [DIV_D_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIV_N_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               start;
      logic [SQ_BITS-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } sqrt_rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FRD_A,
      S_FRD_B,
      S_FRD_C,
      S_FCAP_C,
      S_CROSS,
      S_ACC_RD,
      S_ACC_WR,
      S_Q_RD,
      S_Q_CAP,
      S_DIV_GO,
      S_DIV_WAIT,
      S_NORM_ABS,
      S_NORM_SHIFT,
      S_SQUARE,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_QDIV_GO,
      S_QDIV_WAIT,
      S_OUT
   } state_type;

   // Add with clamp to the signed sum range
   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0] s,
      input logic signed [SUM_BITS-1:0] n
   );
      logic signed [SUM_BITS:0] r;
      r = {s[SUM_BITS-1], s} + {n[SUM_BITS-1], n};
      if (r[SUM_BITS] != r[SUM_BITS-1]) begin
         if (r[SUM_BITS]) begin
            return {1'b1, {(SUM_BITS-1){1'b0}}};
         end
         return {1'b0, {(SUM_BITS-1){1'b1}}};
      end
      return r[SUM_BITS-1:0];
   endfunction

   // Magnitude of a signed sum-width value
   function automatic logic [SUM_BITS-1:0] mag(input logic signed [SUM_BITS-1:0] s);
      logic signed [SUM_BITS-1:0] t;
      t = s[SUM_BITS-1] ? -s : s;
      return t;
   endfunction

endpackage

/* rtl/mvn_divider.sv */
module mvn_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mvn_pkg::div_req_type req,
   output mvn_pkg::div_rsp_type rsp
);

   logic                                 busy_ff;
   logic                                 done_ff;
   logic [mvn_pkg::DIV_CNT_BITS-1:0]     cnt_ff;
   logic [mvn_pkg::DIV_N_BITS-1:0]       quo_ff;
   logic [mvn_pkg::DIV_D_BITS-1:0]       rem_ff;
   logic [mvn_pkg::DIV_D_BITS-1:0]       dsr_ff;

   logic [mvn_pkg::DIV_D_BITS:0]         rem_sh;
   logic                                 ge;
   logic [mvn_pkg::DIV_D_BITS:0]         rem_dif;

   // One restoring step: bring down a dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[mvn_pkg::DIV_N_BITS-1]};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      rem_dif = rem_sh - {1'b0, dsr_ff};
   end

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == mvn_pkg::DIV_CNT_BITS'(mvn_pkg::DIV_N_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift quotient in, keep partial remainder
   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[mvn_pkg::DIV_N_BITS-2:0], ge};
         rem_ff <= ge ? rem_dif[mvn_pkg::DIV_D_BITS-1:0] : rem_sh[mvn_pkg::DIV_D_BITS-1:0];
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/mvn_sqrt.sv */
module mvn_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  mvn_pkg::sqrt_req_type req,
   output mvn_pkg::sqrt_rsp_type rsp
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [mvn_pkg::SQ_BITS-1:0]  x_ff;
   logic [mvn_pkg::SQ_BITS-1:0]  res_ff;
   logic [mvn_pkg::SQ_BITS-1:0]  bit_ff;

   logic [mvn_pkg::SQ_BITS-1:0]  trial;
   logic                         fits;

   always_comb begin
      trial = res_ff + bit_ff;
      fits  = (x_ff >= trial);
   end

   // Sequence control: one result digit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Digit-by-digit root, two radicand bits per step
   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff   <= req.radicand;
         res_ff <= '0;
         bit_ff <= mvn_pkg::SQ_BITS'(1) << (mvn_pkg::SQ_BITS - 2);
      end else if (busy_ff) begin
         if (fits) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff[mvn_pkg::ROOT_BITS-1:0];

endmodule

/* rtl/mesh_vertex_normal_engine.sv */
// Mesh vertex normal engine: per-vertex normals by averaging adjacent face normals.
// Request channel (req_valid/req_stall): op 0 writes a vertex, op 1 adds a face,
// op 2 queries a vertex normal, op 3 clears all sums and counts. Faces and queries
// return one result beat on the rsp_ channel; writes and clears return none.
// Config channel (csr_valid/csr_ready, always ready): index 0 normalize enable,
// index 1 vertex count. Write it only while no request is in flight.
// One request at a time runs through a sequencer that drives one shared
// multiplier, one iterative divider and one iterative square root. A face
// makes three vertex reads, six products and three read-modify-writes. A
// query makes three passes through the divider raw, and six normalized, with
// the shift search and a square root between them. A clear writes one row
// of the accumulation store per cycle.
// After reset the same clearing pass runs before the first request is taken.
// A finished result sits in an output register; the next request is taken
// while it waits, and a following result holds its sequence until rsp_stall
// drops.
module mesh_vertex_normal_engine #(
   parameter int MAX_VERTICES = mvn_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = mvn_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_op,
   input  logic [mvn_pkg::IDX_BITS-1:0]          req_index,
   input  logic signed [mvn_pkg::COORD_PORT_BITS-1:0] req_coord_x,
   input  logic signed [mvn_pkg::COORD_PORT_BITS-1:0] req_coord_y,
   input  logic signed [mvn_pkg::COORD_PORT_BITS-1:0] req_coord_z,
   input  logic [mvn_pkg::CORNER_BITS-1:0]       req_corner_a,
   input  logic [mvn_pkg::CORNER_BITS-1:0]       req_corner_b,
   input  logic [mvn_pkg::CORNER_BITS-1:0]       req_corner_c,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_kind,
   output logic [1:0]                            rsp_status,
   output logic signed [mvn_pkg::OUT_BITS-1:0]   rsp_norm_x,
   output logic signed [mvn_pkg::OUT_BITS-1:0]   rsp_norm_y,
   output logic signed [mvn_pkg::OUT_BITS-1:0]   rsp_norm_z,
   output logic [mvn_pkg::COUNT_BITS-1:0]        rsp_adjacent_faces,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mvn_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [mvn_pkg::VCOUNT_BITS-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int DW = COORD_BITS + 1;
   localparam int VW = 3 * COORD_BITS;
   localparam int SB = mvn_pkg::SUM_BITS;

   // Control and configuration
   mvn_pkg::state_type                   state_ff, state_in;
   mvn_pkg::op_type                      op_ff;
   logic                                 normalize_ff;
   logic [mvn_pkg::VCOUNT_BITS-1:0]      vcount_ff;
   logic [AW-1:0]                        clr_addr_ff;
   logic [2:0]                           step_ff;
   logic [1:0]                           comp_ff;

   // Item and datapath registers
   logic [mvn_pkg::IDX_BITS-1:0]         idx_ff;
   logic                                 idx_ok_ff;
   logic [mvn_pkg::CORNER_BITS-1:0]      corner_ff [3];
   logic signed [COORD_BITS-1:0]         va_ff [3];
   logic signed [DW-1:0]                 u_ff [3];
   logic signed [DW-1:0]                 v_ff [3];
   logic signed [mvn_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [SB-1:0]                 n_ff [3];
   logic signed [SB-1:0]                 sum_ff [3];
   logic [mvn_pkg::COUNT_BITS-1:0]       cnt_ff;
   logic [SB-1:0]                        m_ff [3];
   logic [SB-1:0]                        mx_ff;
   logic [mvn_pkg::SQ_BITS-1:0]          sq_ff;
   logic [mvn_pkg::ROOT_BITS-1:0]        root_ff;
   logic [1:0]                           status_ff;

   // Output register
   logic                                 rsp_valid_ff;
   logic                                 rsp_kind_ff;
   logic [1:0]                           rsp_status_ff;
   logic [mvn_pkg::OUT_BITS-1:0]         rsp_norm_ff [3];
   logic [mvn_pkg::COUNT_BITS-1:0]       rsp_adj_ff;

   // Memories
   logic [VW-1:0]                        vert_mem [MAX_VERTICES];
   logic [VW-1:0]                        vert_rd_ff;
   mvn_pkg::row_type                     row_mem [MAX_VERTICES];
   mvn_pkg::row_type                     row_rd_ff;

   // Combinational signals
   logic                                 accept;
   logic                                 load_out;
   logic [mvn_pkg::CORNER_BITS-1:0]      idx_wide;
   logic                                 idx_ok;
   logic [mvn_pkg::COORD_BITS_MAX-1:0]   cx_ext, cy_ext, cz_ext;
   logic                                 vert_we;
   logic [VW-1:0]                        vert_wdata;
   logic [AW-1:0]                        vert_raddr;
   logic signed [COORD_BITS-1:0]         rd_c [3];
   logic [AW-1:0]                        row_raddr;
   logic                                 row_we;
   logic [AW-1:0]                        row_waddr;
   mvn_pkg::row_type                     row_wdata;
   logic [mvn_pkg::CORNER_BITS-1:0]      cur_corner;
   logic [AW-1:0]                        cur_corner_addr;
   logic [AW-1:0]                        idx_addr;
   logic [mvn_pkg::LIM_BITS-1:0]         lim;
   logic                                 repeat_err;
   logic                                 range_err;
   logic signed [mvn_pkg::MUL_BITS-1:0]  mul_a, mul_b;
   logic signed [mvn_pkg::PROD_BITS-1:0] mul_p;
   logic [2:0]                           stepm1;
   logic [1:0]                           sel_j;
   logic [SB-1:0]                        nabs [3];
   logic [SB-1:0]                        nmax;
   logic                                 mx_high;
   logic                                 mx_low;
   logic [mvn_pkg::DIV_N_BITS-1:0]       qclamp;
   mvn_pkg::div_req_type                 div_req;
   mvn_pkg::div_rsp_type                 div_rsp;
   mvn_pkg::sqrt_req_type                sqrt_req;
   mvn_pkg::sqrt_rsp_type                sqrt_rsp;

   mvn_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   mvn_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   // Handshakes
   assign req_stall = (state_ff != mvn_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_out  = (state_ff == mvn_pkg::S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // Index checks and vertex write data
   always_comb begin
      idx_wide   = {{(mvn_pkg::CORNER_BITS - mvn_pkg::IDX_BITS){1'b0}}, req_index};
      idx_ok     = ({1'b0, idx_wide} < mvn_pkg::LIM_BITS'(MAX_VERTICES));
      cx_ext     = {{(mvn_pkg::COORD_BITS_MAX - mvn_pkg::COORD_PORT_BITS){1'b0}}, req_coord_x};
      cy_ext     = {{(mvn_pkg::COORD_BITS_MAX - mvn_pkg::COORD_PORT_BITS){1'b0}}, req_coord_y};
      cz_ext     = {{(mvn_pkg::COORD_BITS_MAX - mvn_pkg::COORD_PORT_BITS){1'b0}}, req_coord_z};
      vert_wdata = {cz_ext[COORD_BITS-1:0], cy_ext[COORD_BITS-1:0], cx_ext[COORD_BITS-1:0]};
      vert_we    = accept && (mvn_pkg::op_type'(req_op) == mvn_pkg::OP_WRITE) && idx_ok;
   end

   // Face corner checks
   always_comb begin
      if ({6'b0, vcount_ff} > mvn_pkg::LIM_BITS'(MAX_VERTICES)) begin
         lim = mvn_pkg::LIM_BITS'(MAX_VERTICES);
      end else begin
         lim = {6'b0, vcount_ff};
      end
      repeat_err = (corner_ff[0] == corner_ff[1]) || (corner_ff[1] == corner_ff[2]) ||
                   (corner_ff[2] == corner_ff[0]);
      range_err  = ({1'b0, corner_ff[0]} >= lim) || ({1'b0, corner_ff[1]} >= lim) ||
                   ({1'b0, corner_ff[2]} >= lim);
   end

   // Unpack the read vertex
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rd_c[j] = signed'(vert_rd_ff[j*COORD_BITS +: COORD_BITS]);
      end
   end

   // Magnitudes of the average and their maximum
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         nabs[j] = mvn_pkg::mag(n_ff[j]);
      end
      nmax = nabs[0];
      if (nabs[1] > nmax) begin
         nmax = nabs[1];
      end
      if (nabs[2] > nmax) begin
         nmax = nabs[2];
      end
      mx_high = |mx_ff[SB-1:30];
      mx_low  = !mx_ff[29];
   end

   assign cur_corner      = corner_ff[comp_ff];
   assign cur_corner_addr = cur_corner[AW-1:0];
   assign idx_addr        = AW'({{(mvn_pkg::CORNER_BITS - mvn_pkg::IDX_BITS){1'b0}}, idx_ff});
   assign stepm1          = step_ff - 3'd1;
   assign sel_j           = stepm1[2:1];
   assign mul_p           = mul_a * mul_b;
   assign qclamp          = (div_rsp.quotient > mvn_pkg::ONE_Q14) ? mvn_pkg::ONE_Q14 :
                            div_rsp.quotient;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mvn_pkg::S_CLEAR: begin
            if (clr_addr_ff == AW'(MAX_VERTICES - 1)) begin
               state_in = mvn_pkg::S_IDLE;
            end
         end
         mvn_pkg::S_IDLE: begin
            if (accept) begin
               case (mvn_pkg::op_type'(req_op))
                  mvn_pkg::OP_WRITE: state_in = mvn_pkg::S_IDLE;
                  mvn_pkg::OP_FACE:  state_in = mvn_pkg::S_CHECK;
                  mvn_pkg::OP_QUERY: state_in = mvn_pkg::S_Q_RD;
                  mvn_pkg::OP_CLEAR: state_in = mvn_pkg::S_CLEAR;
                  default:           state_in = mvn_pkg::S_IDLE;
               endcase
            end
         end
         mvn_pkg::S_CHECK: begin
            state_in = (repeat_err || range_err) ? mvn_pkg::S_OUT : mvn_pkg::S_FRD_A;
         end
         mvn_pkg::S_FRD_A:  state_in = mvn_pkg::S_FRD_B;
         mvn_pkg::S_FRD_B:  state_in = mvn_pkg::S_FRD_C;
         mvn_pkg::S_FRD_C:  state_in = mvn_pkg::S_FCAP_C;
         mvn_pkg::S_FCAP_C: state_in = mvn_pkg::S_CROSS;
         mvn_pkg::S_CROSS: begin
            if (step_ff == 3'd6) begin
               state_in = mvn_pkg::S_ACC_RD;
            end
         end
         mvn_pkg::S_ACC_RD: state_in = mvn_pkg::S_ACC_WR;
         mvn_pkg::S_ACC_WR: begin
            state_in = (comp_ff == 2'd2) ? mvn_pkg::S_OUT : mvn_pkg::S_ACC_RD;
         end
         mvn_pkg::S_Q_RD: begin
            state_in = idx_ok_ff ? mvn_pkg::S_Q_CAP : mvn_pkg::S_OUT;
         end
         mvn_pkg::S_Q_CAP: begin
            state_in = (row_rd_ff.count == '0) ? mvn_pkg::S_OUT : mvn_pkg::S_DIV_GO;
         end
         mvn_pkg::S_DIV_GO: state_in = mvn_pkg::S_DIV_WAIT;
         mvn_pkg::S_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (comp_ff != 2'd2) begin
                  state_in = mvn_pkg::S_DIV_GO;
               end else if (normalize_ff) begin
                  state_in = mvn_pkg::S_NORM_ABS;
               end else begin
                  state_in = mvn_pkg::S_OUT;
               end
            end
         end
         mvn_pkg::S_NORM_ABS: begin
            state_in = (nmax == '0) ? mvn_pkg::S_OUT : mvn_pkg::S_NORM_SHIFT;
         end
         mvn_pkg::S_NORM_SHIFT: begin
            if (!mx_high && !mx_low) begin
               state_in = mvn_pkg::S_SQUARE;
            end
         end
         mvn_pkg::S_SQUARE: begin
            if (step_ff == 3'd3) begin
               state_in = mvn_pkg::S_SQRT_GO;
            end
         end
         mvn_pkg::S_SQRT_GO: state_in = mvn_pkg::S_SQRT_WAIT;
         mvn_pkg::S_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               state_in = mvn_pkg::S_QDIV_GO;
            end
         end
         mvn_pkg::S_QDIV_GO: state_in = mvn_pkg::S_QDIV_WAIT;
         mvn_pkg::S_QDIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (comp_ff == 2'd2) ? mvn_pkg::S_OUT : mvn_pkg::S_QDIV_GO;
            end
         end
         mvn_pkg::S_OUT: begin
            if (load_out) begin
               state_in = mvn_pkg::S_IDLE;
            end
         end
         default: state_in = mvn_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs: memory ports, shared units, multiplier operands
   always_comb begin
      vert_raddr         = '0;
      row_raddr          = '0;
      row_we             = 1'b0;
      row_waddr          = cur_corner_addr;
      row_wdata          = '0;
      div_req            = '0;
      sqrt_req           = '0;
      mul_a              = '0;
      mul_b              = '0;
      case (state_ff)
         mvn_pkg::S_CLEAR: begin
            row_we    = 1'b1;
            row_waddr = clr_addr_ff;
         end
         mvn_pkg::S_FRD_A: vert_raddr = corner_ff[0][AW-1:0];
         mvn_pkg::S_FRD_B: vert_raddr = corner_ff[1][AW-1:0];
         mvn_pkg::S_FRD_C: vert_raddr = corner_ff[2][AW-1:0];
         mvn_pkg::S_CROSS: begin
            case (step_ff)
               3'd0: begin mul_a = mvn_pkg::MUL_BITS'(u_ff[1]); mul_b = mvn_pkg::MUL_BITS'(v_ff[2]); end
               3'd1: begin mul_a = mvn_pkg::MUL_BITS'(u_ff[2]); mul_b = mvn_pkg::MUL_BITS'(v_ff[1]); end
               3'd2: begin mul_a = mvn_pkg::MUL_BITS'(u_ff[2]); mul_b = mvn_pkg::MUL_BITS'(v_ff[0]); end
               3'd3: begin mul_a = mvn_pkg::MUL_BITS'(u_ff[0]); mul_b = mvn_pkg::MUL_BITS'(v_ff[2]); end
               3'd4: begin mul_a = mvn_pkg::MUL_BITS'(u_ff[0]); mul_b = mvn_pkg::MUL_BITS'(v_ff[1]); end
               3'd5: begin mul_a = mvn_pkg::MUL_BITS'(u_ff[1]); mul_b = mvn_pkg::MUL_BITS'(v_ff[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         mvn_pkg::S_ACC_RD: row_raddr = cur_corner_addr;
         mvn_pkg::S_ACC_WR: begin
            row_we          = (row_rd_ff.count != mvn_pkg::COUNT_MAX);
            row_wdata.sum_x = mvn_pkg::sat_add(row_rd_ff.sum_x, n_ff[0]);
            row_wdata.sum_y = mvn_pkg::sat_add(row_rd_ff.sum_y, n_ff[1]);
            row_wdata.sum_z = mvn_pkg::sat_add(row_rd_ff.sum_z, n_ff[2]);
            row_wdata.count = row_rd_ff.count + 1'b1;
         end
         mvn_pkg::S_Q_RD: row_raddr = idx_addr;
         mvn_pkg::S_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = mvn_pkg::mag(sum_ff[comp_ff]);
            div_req.divisor  = mvn_pkg::DIV_D_BITS'(cnt_ff);
         end
         mvn_pkg::S_SQUARE: begin
            if (step_ff < 3'd3) begin
               mul_a = signed'({1'b0, m_ff[step_ff[1:0]][29:0]});
               mul_b = signed'({1'b0, m_ff[step_ff[1:0]][29:0]});
            end
         end
         mvn_pkg::S_SQRT_GO: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = sq_ff;
         end
         mvn_pkg::S_QDIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = mvn_pkg::DIV_N_BITS'({m_ff[comp_ff][29:0],
                                                     {mvn_pkg::Q14_SHIFT{1'b0}}}) +
                               mvn_pkg::DIV_N_BITS'(root_ff[mvn_pkg::ROOT_BITS-1:1]);
            div_req.divisor  = root_ff;
         end
         default: begin
            row_we = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvn_pkg::S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         normalize_ff <= 1'b1;
         vcount_ff    <= mvn_pkg::VCOUNT_BITS'(1024);
      end else begin
         state_ff <= state_in;
         // advance the clearing sweep; restart it on a clear op
         if (state_ff == mvn_pkg::S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end else begin
            clr_addr_ff <= '0;
         end
         // hold a waiting result until it is taken
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mvn_pkg::CSR_NORMALIZE:    normalize_ff <= csr_wdata[0];
               mvn_pkg::CSR_VERTEX_COUNT: vcount_ff    <= csr_wdata;
               default:                   normalize_ff <= normalize_ff;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         mvn_pkg::S_IDLE: begin
            if (accept) begin
               op_ff        <= mvn_pkg::op_type'(req_op);
               idx_ff       <= req_index;
               idx_ok_ff    <= idx_ok;
               corner_ff[0] <= req_corner_a;
               corner_ff[1] <= req_corner_b;
               corner_ff[2] <= req_corner_c;
               status_ff    <= mvn_pkg::STATUS_OK;
               cnt_ff       <= '0;
               comp_ff      <= '0;
               step_ff      <= '0;
               for (int j = 0; j < 3; j++) begin
                  n_ff[j] <= '0;
               end
            end
         end
         mvn_pkg::S_CHECK: begin
            if (repeat_err) begin
               status_ff <= mvn_pkg::STATUS_REPEAT;
            end else if (range_err) begin
               status_ff <= mvn_pkg::STATUS_RANGE;
            end
         end
         mvn_pkg::S_FRD_B: begin
            for (int j = 0; j < 3; j++) begin
               va_ff[j] <= rd_c[j];
            end
         end
         mvn_pkg::S_FRD_C: begin
            for (int j = 0; j < 3; j++) begin
               u_ff[j] <= DW'(rd_c[j]) - DW'(va_ff[j]);
            end
         end
         mvn_pkg::S_FCAP_C: begin
            for (int j = 0; j < 3; j++) begin
               v_ff[j] <= DW'(rd_c[j]) - DW'(va_ff[j]);
            end
            step_ff <= '0;
         end
         mvn_pkg::S_CROSS: begin
            // product pairs: first of a pair loads, second subtracts
            prod_ff <= mul_p;
            step_ff <= step_ff + 1'b1;
            if (step_ff != 3'd0) begin
               if (!stepm1[0]) begin
                  n_ff[sel_j] <= SB'(prod_ff);
               end else begin
                  n_ff[sel_j] <= n_ff[sel_j] - SB'(prod_ff);
               end
            end
            comp_ff <= '0;
         end
         mvn_pkg::S_ACC_WR: begin
            comp_ff <= comp_ff + 1'b1;
         end
         mvn_pkg::S_Q_RD: begin
            if (!idx_ok_ff) begin
               status_ff <= mvn_pkg::STATUS_RANGE;
            end
         end
         mvn_pkg::S_Q_CAP: begin
            sum_ff[0] <= row_rd_ff.sum_x;
            sum_ff[1] <= row_rd_ff.sum_y;
            sum_ff[2] <= row_rd_ff.sum_z;
            cnt_ff    <= row_rd_ff.count;
            comp_ff   <= '0;
         end
         mvn_pkg::S_DIV_WAIT: begin
            // restore the sign, truncation toward zero
            if (div_rsp.done) begin
               if (sum_ff[comp_ff][SB-1]) begin
                  n_ff[comp_ff] <= -signed'(div_rsp.quotient);
               end else begin
                  n_ff[comp_ff] <= signed'(div_rsp.quotient);
               end
               comp_ff <= comp_ff + 1'b1;
            end
         end
         mvn_pkg::S_NORM_ABS: begin
            for (int j = 0; j < 3; j++) begin
               m_ff[j] <= nabs[j];
            end
            mx_ff <= nmax;
         end
         mvn_pkg::S_NORM_SHIFT: begin
            // shift the vector one bit toward [2^29, 2^30)
            if (mx_high) begin
               for (int j = 0; j < 3; j++) begin
                  m_ff[j] <= m_ff[j] >> 1;
               end
               mx_ff <= mx_ff >> 1;
            end else if (mx_low) begin
               for (int j = 0; j < 3; j++) begin
                  m_ff[j] <= m_ff[j] << 1;
               end
               mx_ff <= mx_ff << 1;
            end
            step_ff <= '0;
         end
         mvn_pkg::S_SQUARE: begin
            prod_ff <= mul_p;
            step_ff <= step_ff + 1'b1;
            if (step_ff == 3'd1) begin
               sq_ff <= $unsigned(prod_ff);
            end else if (step_ff != 3'd0) begin
               sq_ff <= sq_ff + $unsigned(prod_ff);
            end
         end
         mvn_pkg::S_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               root_ff <= sqrt_rsp.root;
               comp_ff <= '0;
            end
         end
         mvn_pkg::S_QDIV_WAIT: begin
            if (div_rsp.done) begin
               if (n_ff[comp_ff][SB-1]) begin
                  n_ff[comp_ff] <= -signed'(qclamp);
               end else begin
                  n_ff[comp_ff] <= signed'(qclamp);
               end
               comp_ff <= comp_ff + 1'b1;
            end
         end
         default: begin
            comp_ff <= comp_ff;
         end
      endcase
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff   <= (op_ff == mvn_pkg::OP_QUERY) ? mvn_pkg::KIND_VERTEX :
                          mvn_pkg::KIND_FACE;
         rsp_status_ff <= status_ff;
         rsp_adj_ff    <= cnt_ff;
         for (int j = 0; j < 3; j++) begin
            rsp_norm_ff[j] <= n_ff[j][mvn_pkg::OUT_BITS-1:0];
         end
      end
   end

   // Vertex store
   always_ff @(posedge clock) begin
      if (vert_we) begin
         vert_mem[idx_wide[AW-1:0]] <= vert_wdata;
      end
      vert_rd_ff <= vert_mem[vert_raddr];
   end

   // Sum and count store
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rd_ff <= row_mem[row_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_norm_x         = signed'(rsp_norm_ff[0]);
   assign rsp_norm_y         = signed'(rsp_norm_ff[1]);
   assign rsp_norm_z         = signed'(rsp_norm_ff[2]);
   assign rsp_adjacent_faces = rsp_adj_ff;

endmodule
